>>> rtl/qrs_pkg.sv
`default_nettype none
package qrs_pkg;

  typedef enum logic [1:0] {
    KIND_NOT_QUAD  = 2'd0,
    KIND_NO_ROOTS  = 2'd1,
    KIND_ONE_ROOT  = 2'd2,
    KIND_TWO_ROOTS = 2'd3
  } root_kind_e;

  localparam int unsigned DiscW = 34;   // b*b - 4*a*c, signed
  localparam int unsigned RadW  = 64;   // disc << 30, unsigned radicand
  localparam int unsigned SqW   = 32;   // floor(sqrt(radicand))
  localparam int unsigned NumW  = 34;   // -b*2^15 +/- s, signed
  localparam int unsigned QuoW  = 34;   // signed quotient width
  localparam int unsigned RootW = 32;

endpackage
`default_nettype wire

>>> rtl/quadratic_root_solver_unit.sv
`default_nettype none
// Quadratic root solver: takes signed Q8.8 coefficients a, b, c and returns
// the kind of solution plus up to two real roots in signed Q16.16, clamped
// with a saturated flag. Fully pipelined: busy is always low, a new
// coefficient set is taken every cycle, and each result appears on the
// result ports with done_o high for one cycle. Each set passes through the
// input and discriminant stages, the restoring square root (32 stages, one
// result bit each), numerator setup, two parallel restoring dividers (34
// stages, one quotient bit each) and the output stage. The receiver cannot
// stall results.
module quadratic_root_solver_unit (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic signed [15:0]  coef_quad_i,
  input  wire logic signed [15:0]  coef_lin_i,
  input  wire logic signed [15:0]  coef_const_i,
  output logic                     done_o,
  output logic [1:0]               root_kind_o,
  output logic signed [31:0]       root_first_o,
  output logic signed [31:0]       root_second_o,
  output logic                     saturated_o
);
  import qrs_pkg::*;

  localparam int unsigned SqSteps  = SqW;
  localparam int unsigned DivSteps = QuoW;

  // never stalls
  assign busy = 1'b0;

  // ---------------- stage 0: capture and products ----------------
  logic                    v0_q;
  logic signed [31:0]      bb_q, ac_q;
  logic signed [15:0]      a0_q, b0_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v0_q <= 1'b0;
    else v0_q <= start;
  end
  always_ff @(posedge clk_i) begin
    bb_q <= 32'(coef_lin_i) * 32'(coef_lin_i);
    ac_q <= 32'(coef_quad_i) * 32'(coef_const_i);
    a0_q <= coef_quad_i;
    b0_q <= coef_lin_i;
  end

  // ---------------- stage 1: discriminant, kind, numerator base ----------
  logic                    v1_q;
  logic signed [DiscW-1:0] disc_d;
  logic [RadW-1:0]         rad1_q;
  logic [1:0]              kind1_q;
  logic signed [15:0]      a1_q;
  logic signed [NumW-1:0]  nb1_q;
  always_comb begin
    disc_d = DiscW'(bb_q) - (DiscW'(ac_q) <<< 2);
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else v1_q <= v0_q;
  end
  always_ff @(posedge clk_i) begin
    if (a0_q == '0) kind1_q <= KIND_NOT_QUAD;
    else if (disc_d[DiscW-1]) kind1_q <= KIND_NO_ROOTS;
    else if (disc_d == '0) kind1_q <= KIND_ONE_ROOT;
    else kind1_q <= KIND_TWO_ROOTS;
    rad1_q <= disc_d[DiscW-1] ? '0 : {disc_d[RadW-31:0], 30'd0};
    a1_q   <= a0_q;
    nb1_q  <= -(NumW'(b0_q) <<< 15);
  end

  // ---------------- square root pipeline, one result bit per stage -------
  // Classic restoring method on (radicand, remainder, root)
  logic                          sv_q    [SqSteps+1];
  logic [RadW-1:0]               srad_q  [SqSteps+1];
  logic [SqW+1:0]                srem_q  [SqSteps+1];
  logic [SqW-1:0]                sroot_q [SqSteps+1];
  logic [1:0]                    skind_q [SqSteps+1];
  logic signed [15:0]            sa_q    [SqSteps+1];
  logic signed [NumW-1:0]        snb_q   [SqSteps+1];

  assign sv_q[0]    = v1_q;
  assign srad_q[0]  = rad1_q;
  assign srem_q[0]  = '0;
  assign sroot_q[0] = '0;
  assign skind_q[0] = kind1_q;
  assign sa_q[0]    = a1_q;
  assign snb_q[0]   = nb1_q;

  for (genvar i = 0; i < SqSteps; i++) begin : g_sqrt
    logic [SqW+1:0] trial, rem_sh;
    always_comb begin
      rem_sh = {srem_q[i][SqW-1:0], srad_q[i][RadW-1 -: 2]};
      trial  = rem_sh - {sroot_q[i], 2'b01};
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) sv_q[i+1] <= 1'b0;
      else sv_q[i+1] <= sv_q[i];
    end
    always_ff @(posedge clk_i) begin
      srad_q[i+1] <= {srad_q[i][RadW-3:0], 2'b00};
      if (!trial[SqW+1]) begin
        srem_q[i+1]  <= trial;
        sroot_q[i+1] <= {sroot_q[i][SqW-2:0], 1'b1};
      end else begin
        srem_q[i+1]  <= rem_sh;
        sroot_q[i+1] <= {sroot_q[i][SqW-2:0], 1'b0};
      end
      skind_q[i+1] <= skind_q[i];
      sa_q[i+1]    <= sa_q[i];
      snb_q[i+1]   <= snb_q[i];
    end
  end

  // ---------------- numerator setup: magnitudes and signs ----------------
  logic                    vn_q;
  logic [NumW-1:0]         n1mag_q, n2mag_q;
  logic                    q1neg_q, q2neg_q;
  logic [15:0]             amag_q;
  logic [1:0]              kindn_q;
  logic signed [NumW-1:0]  n1_d, n2_d;
  logic                    aneg;
  always_comb begin
    aneg = sa_q[SqSteps][15];
    if (skind_q[SqSteps] == KIND_TWO_ROOTS) begin
      n1_d = snb_q[SqSteps] - NumW'(sroot_q[SqSteps]);
      n2_d = snb_q[SqSteps] + NumW'(sroot_q[SqSteps]);
    end else begin
      n1_d = snb_q[SqSteps];
      n2_d = snb_q[SqSteps];
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vn_q <= 1'b0;
    else vn_q <= sv_q[SqSteps];
  end
  always_ff @(posedge clk_i) begin
    n1mag_q <= n1_d[NumW-1] ? -n1_d : n1_d;
    n2mag_q <= n2_d[NumW-1] ? -n2_d : n2_d;
    q1neg_q <= n1_d[NumW-1] ^ aneg;
    q2neg_q <= n2_d[NumW-1] ^ aneg;
    amag_q  <= aneg ? 16'(-sa_q[SqSteps]) : sa_q[SqSteps];
    kindn_q <= skind_q[SqSteps];
  end

  // ---------------- divider pipeline, one quotient bit per stage ---------
  logic                dv_q  [DivSteps+1];
  logic [NumW-1:0]     dn1_q [DivSteps+1], dn2_q [DivSteps+1];
  logic [16:0]         dr1_q [DivSteps+1], dr2_q [DivSteps+1];
  logic [15:0]         dd_q  [DivSteps+1];
  logic [1:0]          dk_q  [DivSteps+1];
  logic                dg1_q [DivSteps+1], dg2_q [DivSteps+1];

  assign dv_q[0]  = vn_q;
  assign dn1_q[0] = n1mag_q;
  assign dn2_q[0] = n2mag_q;
  assign dr1_q[0] = '0;
  assign dr2_q[0] = '0;
  assign dd_q[0]  = amag_q;
  assign dk_q[0]  = kindn_q;
  assign dg1_q[0] = q1neg_q;
  assign dg2_q[0] = q2neg_q;

  // dn holds the remaining numerator bits, shifted out at the top, and the
  // quotient bits shifted in at the bottom
  for (genvar j = 0; j < DivSteps; j++) begin : g_div
    logic [17:0] s1, s2, t1, t2;
    always_comb begin
      s1 = {dr1_q[j], dn1_q[j][NumW-1]};
      s2 = {dr2_q[j], dn2_q[j][NumW-1]};
      t1 = s1 - {2'b00, dd_q[j]};
      t2 = s2 - {2'b00, dd_q[j]};
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) dv_q[j+1] <= 1'b0;
      else dv_q[j+1] <= dv_q[j];
    end
    always_ff @(posedge clk_i) begin
      dn1_q[j+1] <= {dn1_q[j][NumW-2:0], ~t1[17]};
      dn2_q[j+1] <= {dn2_q[j][NumW-2:0], ~t2[17]};
      dr1_q[j+1] <= t1[17] ? s1[16:0] : t1[16:0];
      dr2_q[j+1] <= t2[17] ? s2[16:0] : t2[16:0];
      dd_q[j+1]  <= dd_q[j];
      dk_q[j+1]  <= dk_q[j];
      dg1_q[j+1] <= dg1_q[j];
      dg2_q[j+1] <= dg2_q[j];
    end
  end

  // ---------------- sign restore and clamp ----------------
  logic signed [QuoW:0] r1_d, r2_d;
  logic [RootW-1:0]     c1, c2;
  logic                 o1, o2;
  localparam logic signed [QuoW:0] QMax = (QuoW+1)'(64'sh7FFFFFFF);
  localparam logic signed [QuoW:0] QMin = -(QuoW+1)'(64'sh80000000);
  always_comb begin
    r1_d = dg1_q[DivSteps] ? -$signed({1'b0, dn1_q[DivSteps]})
                           :  $signed({1'b0, dn1_q[DivSteps]});
    r2_d = dg2_q[DivSteps] ? -$signed({1'b0, dn2_q[DivSteps]})
                           :  $signed({1'b0, dn2_q[DivSteps]});
    o1 = (r1_d > QMax) || (r1_d < QMin);
    o2 = (r2_d > QMax) || (r2_d < QMin);
    c1 = (r1_d > QMax) ? 32'h7FFFFFFF : (r1_d < QMin) ? 32'h80000000 : r1_d[RootW-1:0];
    c2 = (r2_d > QMax) ? 32'h7FFFFFFF : (r2_d < QMin) ? 32'h80000000 : r2_d[RootW-1:0];
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_o <= 1'b0;
    else done_o <= dv_q[DivSteps];
  end
  always_ff @(posedge clk_i) begin
    root_kind_o <= dk_q[DivSteps];
    if (dk_q[DivSteps] == KIND_ONE_ROOT || dk_q[DivSteps] == KIND_TWO_ROOTS) begin
      root_first_o  <= c1;
      root_second_o <= c2;
      saturated_o   <= o1 | o2;
    end else begin
      root_first_o  <= '0;
      root_second_o <= '0;
      saturated_o   <= 1'b0;
    end
  end

endmodule
`default_nettype wire

>>> tb/tb_top.sv
module tb_top;
  import qrs_pkg::*;

  localparam int unsigned LatencyCycles = 70;
  localparam int unsigned CycleLimit    = 400000;
  localparam int unsigned RandomItems   = 1080;

  // Expected root set for one coefficient transfer
  typedef struct packed {
    root_kind_e        kind;
    logic signed [31:0] first;
    logic signed [31:0] second;
    logic              sat;
  } root_set_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic signed [15:0] coef_quad_i = '0;
  logic signed [15:0] coef_lin_i = '0;
  logic signed [15:0] coef_const_i = '0;
  logic               done_o;
  logic [1:0]         root_kind_o;
  logic signed [31:0] root_first_o;
  logic signed [31:0] root_second_o;
  logic               saturated_o;

  root_set_t   pending_roots[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;

  quadratic_root_solver_unit u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .coef_quad_i  (coef_quad_i),
    .coef_lin_i   (coef_lin_i),
    .coef_const_i (coef_const_i),
    .done_o       (done_o),
    .root_kind_o  (root_kind_o),
    .root_first_o (root_first_o),
    .root_second_o(root_second_o),
    .saturated_o  (saturated_o)
  );

  always #5 clk_i = ~clk_i;

  // floor(sqrt(x)), bit-serial
  function automatic logic [63:0] int_sqrt(input logic [63:0] x);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bit_w;
    rem = x;
    res = '0;
    bit_w = 64'd1 << 62;
    while (bit_w > rem) bit_w = bit_w >> 2;
    while (bit_w != 0) begin
      if (rem >= res + bit_w) begin
        rem = rem - (res + bit_w);
        res = (res >> 1) + bit_w;
      end else begin
        res = res >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return res;
  endfunction

  // Clamp to Q16.16, flag on saturation
  function automatic logic signed [31:0] clamp_root(input longint v, inout logic sat);
    if (v > 64'sd2147483647) begin
      sat = 1'b1;
      return 32'sh7fffffff;
    end
    if (v < -64'sd2147483648) begin
      sat = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic root_set_t solve_roots(input logic signed [15:0] qa,
                                            input logic signed [15:0] qb,
                                            input logic signed [15:0] qc);
    root_set_t r;
    longint    a;
    longint    b;
    longint    c;
    longint    disc;
    longint    nb;
    longint    s;
    logic      sat;
    a = qa;
    b = qb;
    c = qc;
    sat = 1'b0;
    r = '{kind: KIND_NOT_QUAD, first: '0, second: '0, sat: 1'b0};
    if (a == 0) return r;
    disc = b * b - 4 * a * c;
    if (disc < 0) begin
      r.kind = KIND_NO_ROOTS;
      return r;
    end
    nb = -b * 32768;
    if (disc == 0) begin
      r.kind = KIND_ONE_ROOT;
      r.first = clamp_root(nb / a, sat);
      r.second = r.first;
    end else begin
      s = longint'(int_sqrt(64'(disc) << 30));
      r.kind = KIND_TWO_ROOTS;
      r.first = clamp_root((nb - s) / a, sat);
      r.second = clamp_root((nb + s) / a, sat);
    end
    r.sat = sat;
    return r;
  endfunction

  // Send one coefficient set, after a random gap when gaps is set
  task automatic send_coefs(input logic signed [15:0] qa,
                            input logic signed [15:0] qb,
                            input logic signed [15:0] qc,
                            input bit gaps);
    int unsigned gap;
    gap = gaps ? $urandom_range(14, 0) : 0;
    repeat (gap) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start <= 1'b1;
    coef_quad_i <= qa;
    coef_lin_i <= qb;
    coef_const_i <= qc;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pending_roots.push_back(solve_roots(qa, qb, qc));
    @(negedge clk_i);
  endtask

  task automatic end_stream();
    start <= 1'b0;
  endtask

  // Directed: extremes and each solution kind
  task automatic test_directed();
    send_coefs(16'sd0, 16'sd256, 16'sd256, 0);          // not quadratic
    send_coefs(16'sd0, -16'sd32768, 16'sd32767, 0);
    send_coefs(16'sd256, 16'sd0, 16'sd256, 0);          // no real roots
    send_coefs(-16'sd32768, 16'sd0, -16'sd32768, 0);
    send_coefs(16'sd256, -16'sd512, 16'sd256, 0);       // one root at 1
    send_coefs(16'sd256, 16'sd0, 16'sd0, 0);            // one root at 0
    send_coefs(16'sd1, 16'sd2, 16'sd1, 0);              // one root at -1
    send_coefs(16'sd256, 16'sd0, -16'sd256, 0);         // two roots
    send_coefs(-16'sd256, 16'sd0, 16'sd256, 0);         // two roots, a < 0
    send_coefs(16'sd1, -16'sd32768, 16'sd0, 0);         // saturation
    send_coefs(-16'sd1, 16'sd32767, 16'sd0, 0);
    send_coefs(16'sd1, 16'sd0, -16'sd32768, 0);
    send_coefs(16'sd32767, 16'sd32767, -16'sd32768, 0);
    send_coefs(-16'sd32768, -16'sd32768, 16'sd32767, 0);
    send_coefs(16'sd32767, -16'sd32768, -16'sd32768, 1);
    send_coefs(-16'sd1, -16'sd1, -16'sd1, 1);
    send_coefs(16'sd1, 16'sd1, 16'sd0, 1);
    send_coefs(-16'sd32768, 16'sd0, 16'sd0, 1);
  endtask

  // Random: mix of full range, small values and forced root kinds
  task automatic test_random();
    logic signed [15:0] qa;
    logic signed [15:0] qb;
    logic signed [15:0] qc;
    logic signed [15:0] root_v;
    bit                 gaps;
    gaps = 1'b1;
    for (int i = 0; i < RandomItems; i++) begin
      if (i % 150 == 0) gaps = ($urandom_range(2, 0) != 0);
      qa = 16'($urandom);
      qb = 16'($urandom);
      qc = 16'($urandom);
      case ($urandom_range(5, 0))
        0: qa = '0;
        1: begin
          qa = 16'($signed($urandom_range(1023, 0)) - 512);
          qb = 16'($signed($urandom_range(1023, 0)) - 512);
          qc = 16'($signed($urandom_range(1023, 0)) - 512);
        end
        2: begin
          // perfect square a*(x-r)^2 with a=1 gives zero discriminant
          root_v = 16'($signed($urandom_range(255, 0)) - 128);
          qa = 16'sd1;
          qb = -16'sd2 * root_v;
          qc = root_v * root_v;
        end
        3: qc = (qa[15] == qc[15]) ? -qc : qc;  // ac <= 0, real roots
        default: ;
      endcase
      send_coefs(qa, qb, qc, gaps);
    end
    end_stream();
  endtask

  // Compare each result with the oldest expectation
  always @(posedge clk_i) begin
    root_set_t exp_r;
    if (rst_ni && done_o) begin
      if (pending_roots.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result transfer");
      end else begin
        exp_r = pending_roots.pop_front();
        if (root_kind_o !== exp_r.kind || root_first_o !== exp_r.first ||
            root_second_o !== exp_r.second || saturated_o !== exp_r.sat) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: exp kind %0d %0d %0d sat %0b, got kind %0d %0d %0d sat %0b",
                     exp_r.kind, exp_r.first, exp_r.second, exp_r.sat,
                     root_kind_o, root_first_o, root_second_o, saturated_o);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random();
    while (pending_roots.size() != 0) @(posedge clk_i);
    repeat (LatencyCycles + 10) @(posedge clk_i);
    if (mismatch_count == 0 && pending_roots.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
